// ===== hw/rtl/midpoint_circle_generator_assert.svh =====
// Assertion macros shared by the circle generator RTL.
`ifndef MIDPOINT_CIRCLE_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcg_pkg.sv =====
// Shared types and constants of the midpoint circle generator.
package mcg_pkg;

    localparam int COORD_W     = 12;
    localparam int RADIUS_W    = 10;
    localparam int POINT_W     = 14;
    localparam int OFFX_W      = 11;
    localparam int OFFY_W      = 12;
    localparam int DEC_W       = 16;
    localparam int SPAN_W      = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int PHASE_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [SPAN_W-1:0]  off_x;
        logic [SPAN_W-1:0]  off_y;
        logic               done;
    } step_t;

    typedef struct packed {
        logic  valid;
        step_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/mcg_if.sv =====
// Valid/ready channel interfaces for command items and plotted points.
interface mcg_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [mcg_pkg::RADIUS_W-1:0] radius;

    modport source (output valid, output kind, output radius, input ready);
    modport sink   (input valid, input kind, input radius, output ready);
endinterface

interface mcg_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mcg_pkg::POINT_W-1:0] point_x;
    logic signed [mcg_pkg::POINT_W-1:0] point_y;
    logic                             step_last;
    logic                             circle_done;

    modport source (output valid, output point_x, output point_y, output step_last,
                    output circle_done, input ready);
    modport sink   (input valid, input point_x, input point_y, input step_last,
                    input circle_done, output ready);
endinterface

// ===== hw/rtl/mcg_front.sv =====
// Front end: accepts commands, runs the midpoint decision update, queues steps.
`include "midpoint_circle_generator_assert.svh"

module mcg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    mcg_in_if.sink                        item,
    input  logic [mcg_pkg::COORD_W-1:0]   center_x,
    input  logic [mcg_pkg::COORD_W-1:0]   center_y,
    input  mcg_pkg::queue_status_t        qstat,
    output mcg_pkg::push_t                push
);

    logic        [mcg_pkg::OFFX_W-1:0] off_x_reg, off_x_next;
    logic signed [mcg_pkg::OFFY_W-1:0] off_y_reg, off_y_next;
    logic signed [mcg_pkg::DEC_W-1:0]  dec_reg, dec_next;
    logic                              active_reg, active_next;

    logic                              accept;
    logic                              is_start;
    logic                              can_step;
    logic signed [mcg_pkg::DEC_W-1:0]  x_ext;
    logic signed [mcg_pkg::DEC_W-1:0]  y_ext;
    logic signed [mcg_pkg::DEC_W-1:0]  r_ext;
    logic signed [mcg_pkg::DEC_W-1:0]  dec_step;
    logic        [mcg_pkg::OFFX_W-1:0] new_x;
    logic signed [mcg_pkg::OFFY_W-1:0] new_y;
    logic                              step_done;

    assign item.ready = !qstat.full;
    assign accept     = item.valid && item.ready;
    assign is_start   = (item.kind == mcg_pkg::KIND_START);
    assign can_step   = active_reg && ($signed({1'b0, off_x_reg}) <= off_y_reg);

    assign x_ext = $signed({{(mcg_pkg::DEC_W-mcg_pkg::OFFX_W){1'b0}}, off_x_reg});
    assign y_ext = $signed({{(mcg_pkg::DEC_W-mcg_pkg::OFFY_W){off_y_reg[mcg_pkg::OFFY_W-1]}},
                            off_y_reg});
    assign r_ext = $signed({{(mcg_pkg::DEC_W-mcg_pkg::RADIUS_W){1'b0}}, item.radius});

    // d < 0: d += 4x + 6 ; otherwise d += 4(x - y) + 10 and y steps down
    assign dec_step = dec_reg[mcg_pkg::DEC_W-1]
                    ? dec_reg + (x_ext <<< 2) + 16'sd6
                    : dec_reg + ((x_ext - y_ext) <<< 2) + 16'sd10;
    assign new_y    = dec_reg[mcg_pkg::DEC_W-1] ? off_y_reg : off_y_reg - 12'sd1;
    assign new_x    = off_x_reg + 1'b1;
    assign step_done = (new_y < $signed({1'b0, new_x}));

    always_comb
    begin
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (is_start)
            begin
                off_x_next  = '0;
                off_y_next  = $signed({{(mcg_pkg::OFFY_W-mcg_pkg::RADIUS_W){1'b0}},
                                       item.radius});
                dec_next    = 16'sd3 - (r_ext <<< 1);
                active_next = 1'b1;
            end
            else if (can_step)
            begin
                off_x_next  = new_x;
                off_y_next  = new_y;
                dec_next    = dec_step;
                active_next = !step_done;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            off_x_reg  <= off_x_next;
            off_y_reg  <= off_y_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
        end
    end

    assign push.valid          = accept && !is_start && can_step;
    assign push.entry.center_x = center_x;
    assign push.entry.center_y = center_y;
    assign push.entry.off_x    = off_x_reg;
    assign push.entry.off_y    = off_y_reg[mcg_pkg::SPAN_W-1:0];
    assign push.entry.done     = step_done;

    `MCG_ASSERT_NEXT(a_start_arms, accept && is_start, active_reg,
        "start transaction did not arm the circle")

endmodule

// ===== hw/rtl/mcg_queue.sv =====
// Small register queue of pending steps between front and back end.
`include "midpoint_circle_generator_assert.svh"

module mcg_queue #(
    parameter int DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcg_pkg::push_t         push,
    input  logic                   pop,
    output mcg_pkg::step_t         head,
    output mcg_pkg::queue_status_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcg_pkg::step_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign head        = entries_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `MCG_ASSERT_NOW(a_no_overflow, push.valid, !qstat.full || pop,
        "step queued while queue full")
    `MCG_ASSERT_NOW(a_no_underflow, pop, !qstat.empty,
        "step retired from empty queue")

endmodule

// ===== hw/rtl/mcg_back.sv =====
// Back end: expands one queued step into its eight symmetric points.
`include "midpoint_circle_generator_assert.svh"

module mcg_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcg_pkg::step_t         head,
    input  mcg_pkg::queue_status_t qstat,
    output logic                   pop,
    mcg_out_if.source              point
);

    logic                               valid_reg, valid_next;
    logic        [mcg_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic signed [mcg_pkg::POINT_W-1:0] px_reg;
    logic signed [mcg_pkg::POINT_W-1:0] py_reg;
    logic                               last_reg;
    logic                               done_reg;

    logic                               load;
    logic                               last_pt;
    logic        [mcg_pkg::SPAN_W-1:0]  a_off;
    logic        [mcg_pkg::SPAN_W-1:0]  b_off;
    logic        [mcg_pkg::POINT_W-1:0] cx_ext;
    logic        [mcg_pkg::POINT_W-1:0] cy_ext;
    logic        [mcg_pkg::POINT_W-1:0] a_ext;
    logic        [mcg_pkg::POINT_W-1:0] b_ext;
    logic        [mcg_pkg::POINT_W-1:0] px;
    logic        [mcg_pkg::POINT_W-1:0] py;

    assign load    = !qstat.empty && (!valid_reg || point.ready);
    assign last_pt = (phase_reg == mcg_pkg::PHASE_LAST);
    assign pop     = load && last_pt;

    // phase bit 0 swaps x/y, bit 1 mirrors in x, bit 2 mirrors in y
    assign a_off  = phase_reg[0] ? head.off_y : head.off_x;
    assign b_off  = phase_reg[0] ? head.off_x : head.off_y;
    assign cx_ext = {{(mcg_pkg::POINT_W-mcg_pkg::COORD_W){1'b0}}, head.center_x};
    assign cy_ext = {{(mcg_pkg::POINT_W-mcg_pkg::COORD_W){1'b0}}, head.center_y};
    assign a_ext  = {{(mcg_pkg::POINT_W-mcg_pkg::SPAN_W){1'b0}}, a_off};
    assign b_ext  = {{(mcg_pkg::POINT_W-mcg_pkg::SPAN_W){1'b0}}, b_off};
    assign px     = phase_reg[1] ? cx_ext - a_ext : cx_ext + a_ext;
    assign py     = phase_reg[2] ? cy_ext - b_ext : cy_ext + b_ext;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = phase_reg + 1'b1;
        end
        else if (point.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= $signed(px);
            py_reg   <= $signed(py);
            last_reg <= last_pt;
            done_reg <= last_pt && head.done;
        end
    end

    assign point.valid       = valid_reg;
    assign point.point_x     = px_reg;
    assign point.point_y     = py_reg;
    assign point.step_last   = last_reg;
    assign point.circle_done = done_reg;

    `MCG_ASSERT_NOW(a_done_on_last, valid_reg && done_reg, last_reg,
        "circle_done on a point that is not the last of its step")
    `MCG_ASSERT_NEXT(a_pop_wraps, pop, phase_reg == '0,
        "step retired without phase wrapping to first point")

endmodule

// ===== hw/rtl/midpoint_circle_generator.sv =====
// Top level of the midpoint circle generator.
// Usage: write center_x (index 0) and center_y (index 1) while idle, send a start
// transaction (kind 0) with the radius, then one step transaction (kind 1) per octant
// step. Each step yields eight point transactions, one per cycle while the output is
// ready, in fixed symmetric order; the eighth carries step_last, and on the circle's
// final step also circle_done. Steps sent while no circle is active yield nothing.
// Command transactions are taken back to back while the step queue has room;
// sustained throughput is one step per eight points, set by the single-point-per-cycle
// output register of the point expander. An accepted step is written into the step
// queue and then loaded into that output register before its first point appears.
module midpoint_circle_generator #(
    parameter int QUEUE_DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mcg_in_if.sink                          item,
    mcg_out_if.source                       point,
    input  logic                            cfg_we,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcg_pkg::COORD_W-1:0]     cfg_data
);

    logic [mcg_pkg::COORD_W-1:0] center_x_reg, center_x_next;
    logic [mcg_pkg::COORD_W-1:0] center_y_reg, center_y_next;

    mcg_pkg::push_t         push;
    mcg_pkg::step_t         head;
    mcg_pkg::queue_status_t qstat;
    logic                   pop;

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mcg_pkg::CFG_CENTER_X: center_x_next = cfg_data;
                mcg_pkg::CFG_CENTER_Y: center_y_next = cfg_data;
                default:               center_x_next = center_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    mcg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .qstat    (qstat),
        .push     (push)
    );

    mcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    mcg_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .point (point)
    );

endmodule
